### src/depth_pixel_back_projection_top_defines.svh
// Assertion macros for the depth pixel back-projection block.
// They sample on clk and are disabled while rst_n is low.
`ifndef DEPTH_PIXEL_BACK_PROJECTION_TOP_DEFINES_SVH
`define DEPTH_PIXEL_BACK_PROJECTION_TOP_DEFINES_SVH

// Same-cycle implication.
`define DPBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpbp assertion failed");

// Next-cycle implication.
`define DPBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpbp assertion failed");

`endif

### src/dpbp_pkg.sv
package dpbp_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int DEPTH_W     = 24;
    localparam int RAW_W       = 16;
    localparam int CHAN_W      = 8;
    localparam int POINT_W     = 32;
    localparam int CENTRE_W    = 16;
    localparam int INV_W       = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_SCALE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MIN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MAX       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_FLOOR      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESIDUAL_ENABLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RESIDUAL_LIMIT  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PRINCIPAL_POINT = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_FOCAL   = 3'd7;

    localparam logic [DEPTH_W-1:0]    DEPTH_SCALE_RST    = 24'd16777;
    localparam logic [DEPTH_W-1:0]    DEPTH_MIN_RST      = 24'd3277;
    localparam logic [DEPTH_W-1:0]    DEPTH_MAX_RST      = 24'd163840;
    localparam logic [CHAN_W-1:0]     MASK_FLOOR_RST     = 8'd128;
    localparam logic                  RESIDUAL_EN_RST    = 1'b0;
    localparam logic [DEPTH_W-1:0]    RESIDUAL_LIMIT_RST = 24'd1638;
    localparam logic [2*CENTRE_W-1:0] PRINCIPAL_RST      = 32'd0;
    localparam logic [2*INV_W-1:0]    INVERSE_FOCAL_RST  = 64'd0;

    localparam logic [DEPTH_W-1:0] Z_MAX     = 24'hFFFFFF;
    localparam logic [CHAN_W-1:0]  GREY_MAX  = 8'hFF;
    localparam logic [POINT_W-1:0] POS_LIMIT = 32'h7FFFFFFF;
    localparam logic [POINT_W-1:0] NEG_LIMIT = 32'h80000000;

endpackage

### src/dpbp_if.sv
interface dpbp_pixel_if #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         column;
    logic [COORD_BITS-1:0]         row;
    logic [dpbp_pkg::RAW_W-1:0]    raw_depth;
    logic [dpbp_pkg::CHAN_W-1:0]   mask_value;
    logic                          mask_present;
    logic [dpbp_pkg::CHAN_W-1:0]   red_in;
    logic [dpbp_pkg::CHAN_W-1:0]   green_in;
    logic [dpbp_pkg::CHAN_W-1:0]   blue_in;
    logic                          color_present;
    logic [dpbp_pkg::DEPTH_W-1:0]  gate_root_depth;

    modport source (
        output valid, column, row, raw_depth, mask_value, mask_present,
               red_in, green_in, blue_in, color_present, gate_root_depth,
        input  ready
    );
    modport sink (
        input  valid, column, row, raw_depth, mask_value, mask_present,
               red_in, green_in, blue_in, color_present, gate_root_depth,
        output ready
    );
endinterface

interface dpbp_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [dpbp_pkg::POINT_W-1:0] point_x;
    logic signed [dpbp_pkg::POINT_W-1:0] point_y;
    logic [dpbp_pkg::DEPTH_W-1:0]        point_z;
    logic [dpbp_pkg::CHAN_W-1:0]         red_out;
    logic [dpbp_pkg::CHAN_W-1:0]         green_out;
    logic [dpbp_pkg::CHAN_W-1:0]         blue_out;

    modport source (
        output valid, point_x, point_y, point_z, red_out, green_out, blue_out,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, red_out, green_out, blue_out,
        output ready
    );
endinterface

### src/depth_pixel_back_projection_top.sv
// Channel   Dir  Transaction
// pixel     in   one depth pixel with coordinates, mask, color, root depth
// point     out  one back-projected point with color (none for a rejected pixel)
// write_*   in   configuration register write, no handshake
//
// Five register stages: depth product, depth rounding and offsets, range checks
// and offset*depth product, focal products (split 32-bit partial products),
// round/saturate into the output register. One transaction per clock unless stalled.
// A full output stage that is not taken stalls every stage at once.
// rst_n is asynchronous, clears valid bits and loads configuration defaults.
`include "depth_pixel_back_projection_top_defines.svh"

module depth_pixel_back_projection_top #(
    parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  write_enable,
    input  logic [dpbp_pkg::CFG_INDEX_W-1:0]      write_index,
    input  logic [dpbp_pkg::CFG_DATA_W-1:0]       write_data,
    dpbp_pixel_if.sink                            pixel,
    dpbp_point_if.source                          point
);

    localparam int DEPTH_W = dpbp_pkg::DEPTH_W;
    localparam int CHAN_W  = dpbp_pkg::CHAN_W;
    localparam int CW4     = COORD_BITS + 4;
    localparam int DW      = (CW4 > dpbp_pkg::CENTRE_W) ? CW4 : dpbp_pkg::CENTRE_W;
    localparam int PW      = DW + DEPTH_W;
    localparam int HW      = PW - dpbp_pkg::INV_W;
    localparam int MW      = HW + dpbp_pkg::INV_W + 2;
    localparam int ZP_W    = dpbp_pkg::RAW_W + DEPTH_W;

    // configuration
    logic [DEPTH_W-1:0]                 depth_scale_reg;
    logic [DEPTH_W-1:0]                 depth_min_reg;
    logic [DEPTH_W-1:0]                 depth_max_reg;
    logic [CHAN_W-1:0]                  mask_floor_reg;
    logic                               residual_enable_reg;
    logic [DEPTH_W-1:0]                 residual_limit_reg;
    logic [2*dpbp_pkg::CENTRE_W-1:0]    principal_point_reg;
    logic [2*dpbp_pkg::INV_W-1:0]       inverse_focal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_scale_reg     <= dpbp_pkg::DEPTH_SCALE_RST;
            depth_min_reg       <= dpbp_pkg::DEPTH_MIN_RST;
            depth_max_reg       <= dpbp_pkg::DEPTH_MAX_RST;
            mask_floor_reg      <= dpbp_pkg::MASK_FLOOR_RST;
            residual_enable_reg <= dpbp_pkg::RESIDUAL_EN_RST;
            residual_limit_reg  <= dpbp_pkg::RESIDUAL_LIMIT_RST;
            principal_point_reg <= dpbp_pkg::PRINCIPAL_RST;
            inverse_focal_reg   <= dpbp_pkg::INVERSE_FOCAL_RST;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                dpbp_pkg::REG_DEPTH_SCALE:     depth_scale_reg     <= write_data[DEPTH_W-1:0];
                dpbp_pkg::REG_DEPTH_MIN:       depth_min_reg       <= write_data[DEPTH_W-1:0];
                dpbp_pkg::REG_DEPTH_MAX:       depth_max_reg       <= write_data[DEPTH_W-1:0];
                dpbp_pkg::REG_MASK_FLOOR:      mask_floor_reg      <= write_data[CHAN_W-1:0];
                dpbp_pkg::REG_RESIDUAL_ENABLE: residual_enable_reg <= write_data[0];
                dpbp_pkg::REG_RESIDUAL_LIMIT:  residual_limit_reg  <= write_data[DEPTH_W-1:0];
                dpbp_pkg::REG_PRINCIPAL_POINT:
                    principal_point_reg <= write_data[2*dpbp_pkg::CENTRE_W-1:0];
                dpbp_pkg::REG_INVERSE_FOCAL:   inverse_focal_reg   <= write_data;
            endcase
        end
    end

    // pipeline control: all stages advance together
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_valid_next, s3_valid_next;
    logic adv;

    assign adv         = !s5_valid_reg || point.ready;
    assign pixel.ready = adv;

    // stage 1: raw * scale
    logic [ZP_W-1:0]        s1_zprod_reg;
    logic [COORD_BITS-1:0]  s1_col_reg, s1_row_reg;
    logic [3*CHAN_W-1:0]    s1_rgb_reg;
    logic                   s1_cpres_reg;
    logic [DEPTH_W-1:0]     s1_root_reg;

    assign s1_valid_next = pixel.valid
                        && !(pixel.mask_present && (pixel.mask_value < mask_floor_reg))
                        && (pixel.raw_depth != '0);

    // stage 2: z rounding and centre offsets
    logic [ZP_W:0]          zsum;
    logic [ZP_W-8:0]        zsh;
    logic [DEPTH_W-1:0]     z_next;
    logic [DW:0]            dx_diff, dy_diff;
    logic [DW-1:0]          dx_next, dy_next;

    logic [DEPTH_W-1:0]     s2_z_reg;
    logic [DW-1:0]          s2_dx_reg, s2_dy_reg;
    logic                   s2_negx_reg, s2_negy_reg;
    logic [3*CHAN_W-1:0]    s2_rgb_reg;
    logic                   s2_cpres_reg;
    logic [DEPTH_W-1:0]     s2_root_reg;

    always_comb
    begin
        zsum   = (ZP_W+1)'(s1_zprod_reg) + (ZP_W+1)'(128);
        zsh    = zsum[ZP_W:8];
        z_next = (|zsh[ZP_W-8:DEPTH_W]) ? dpbp_pkg::Z_MAX : zsh[DEPTH_W-1:0];
        dx_diff = (DW+1)'({s1_col_reg, 4'b0000})
                - (DW+1)'(principal_point_reg[dpbp_pkg::CENTRE_W-1:0]);
        dy_diff = (DW+1)'({s1_row_reg, 4'b0000})
                - (DW+1)'(principal_point_reg[2*dpbp_pkg::CENTRE_W-1:dpbp_pkg::CENTRE_W]);
        dx_next = dx_diff[DW] ? DW'(-dx_diff) : dx_diff[DW-1:0];
        dy_next = dy_diff[DW] ? DW'(-dy_diff) : dy_diff[DW-1:0];
    end

    // stage 3: acceptance checks, offset * z, grey level
    logic [DEPTH_W-1:0]     res_diff;
    logic                   res_reject;
    logic [31:0]            grey_prod;
    logic [CHAN_W-1:0]      grey;

    logic [PW-1:0]          s3_px_reg, s3_py_reg;
    logic                   s3_negx_reg, s3_negy_reg;
    logic [DEPTH_W-1:0]     s3_z_reg;
    logic [3*CHAN_W-1:0]    s3_rgb_reg;

    always_comb
    begin
        res_diff   = (s2_z_reg > s2_root_reg) ? (s2_z_reg - s2_root_reg)
                                              : (s2_root_reg - s2_z_reg);
        res_reject = residual_enable_reg && (s2_root_reg != '0)
                  && (res_diff > residual_limit_reg);
        s3_valid_next = s2_valid_reg && (s2_z_reg != '0) && !res_reject
                     && (s2_z_reg >= depth_min_reg) && (s2_z_reg <= depth_max_reg);
        grey_prod = {s2_z_reg, 8'h00} - 32'(s2_z_reg);
        grey      = (|grey_prod[31:24]) ? dpbp_pkg::GREY_MAX : grey_prod[23:16];
    end

    // stage 4: split products with the inverse focal lengths
    logic [63:0]            s4_lox_reg, s4_loy_reg;
    logic [HW+31:0]         s4_hix_reg, s4_hiy_reg;
    logic                   s4_negx_reg, s4_negy_reg;
    logic [DEPTH_W-1:0]     s4_z_reg;
    logic [3*CHAN_W-1:0]    s4_rgb_reg;

    // stage 5: round, saturate
    function automatic logic [dpbp_pkg::POINT_W-1:0] round_sat(
        input logic [HW+31:0] hi,
        input logic [63:0]    lo,
        input logic           neg
    );
        logic [MW-1:0]   m;
        logic [MW-5:0]   mag;
        logic [dpbp_pkg::POINT_W-1:0] r;
        m   = MW'(hi) + MW'(lo[63:32]) + MW'(8);
        mag = m[MW-1:4];
        if (neg)
        begin
            if (mag > (MW-4)'(dpbp_pkg::NEG_LIMIT))
                r = dpbp_pkg::NEG_LIMIT;
            else
                r = -mag[dpbp_pkg::POINT_W-1:0];
        end
        else
        begin
            if (mag > (MW-4)'(dpbp_pkg::POS_LIMIT))
                r = dpbp_pkg::POS_LIMIT;
            else
                r = mag[dpbp_pkg::POINT_W-1:0];
        end
        return r;
    endfunction

    logic [dpbp_pkg::POINT_W-1:0] s5_x_reg, s5_y_reg;
    logic [DEPTH_W-1:0]           s5_z_reg;
    logic [3*CHAN_W-1:0]          s5_rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_zprod_reg <= ZP_W'(pixel.raw_depth) * ZP_W'(depth_scale_reg);
            s1_col_reg   <= pixel.column;
            s1_row_reg   <= pixel.row;
            s1_rgb_reg   <= {pixel.red_in, pixel.green_in, pixel.blue_in};
            s1_cpres_reg <= pixel.color_present;
            s1_root_reg  <= pixel.gate_root_depth;

            s2_z_reg     <= z_next;
            s2_dx_reg    <= dx_next;
            s2_dy_reg    <= dy_next;
            s2_negx_reg  <= dx_diff[DW];
            s2_negy_reg  <= dy_diff[DW];
            s2_rgb_reg   <= s1_rgb_reg;
            s2_cpres_reg <= s1_cpres_reg;
            s2_root_reg  <= s1_root_reg;

            s3_px_reg    <= PW'(s2_dx_reg) * PW'(s2_z_reg);
            s3_py_reg    <= PW'(s2_dy_reg) * PW'(s2_z_reg);
            s3_negx_reg  <= s2_negx_reg;
            s3_negy_reg  <= s2_negy_reg;
            s3_z_reg     <= s2_z_reg;
            s3_rgb_reg   <= s2_cpres_reg ? s2_rgb_reg : {grey, grey, grey};

            s4_lox_reg   <= 64'(s3_px_reg[31:0]) * 64'(inverse_focal_reg[31:0]);
            s4_loy_reg   <= 64'(s3_py_reg[31:0]) * 64'(inverse_focal_reg[63:32]);
            s4_hix_reg   <= (HW+32)'(s3_px_reg[PW-1:32]) * (HW+32)'(inverse_focal_reg[31:0]);
            s4_hiy_reg   <= (HW+32)'(s3_py_reg[PW-1:32]) * (HW+32)'(inverse_focal_reg[63:32]);
            s4_negx_reg  <= s3_negx_reg;
            s4_negy_reg  <= s3_negy_reg;
            s4_z_reg     <= s3_z_reg;
            s4_rgb_reg   <= s3_rgb_reg;

            s5_x_reg     <= round_sat(s4_hix_reg, s4_lox_reg, s4_negx_reg);
            s5_y_reg     <= round_sat(s4_hiy_reg, s4_loy_reg, s4_negy_reg);
            s5_z_reg     <= s4_z_reg;
            s5_rgb_reg   <= s4_rgb_reg;
        end
    end

    assign point.valid     = s5_valid_reg;
    assign point.point_x   = s5_x_reg;
    assign point.point_y   = s5_y_reg;
    assign point.point_z   = s5_z_reg;
    assign point.red_out   = s5_rgb_reg[3*CHAN_W-1:2*CHAN_W];
    assign point.green_out = s5_rgb_reg[2*CHAN_W-1:CHAN_W];
    assign point.blue_out  = s5_rgb_reg[CHAN_W-1:0];

    `DPBP_ASSERT_NOW(a_point_has_depth, s5_valid_reg, s5_z_reg != '0)
    `DPBP_ASSERT_NEXT(a_zero_raw_dropped, pixel.valid && adv && (pixel.raw_depth == '0),
        !s1_valid_reg)
    `DPBP_ASSERT_NEXT(a_stall_holds_pipe, !adv,
        $stable(s4_valid_reg) && $stable(s3_valid_reg) && $stable(s4_z_reg))

endmodule
